[design/httpf_pkg.sv]
// Package for the HTTP request framer: payload structs, framing state,
// line-parser phases and byte classification helpers. No dependencies.
package httpf_pkg;

  localparam int unsigned CountW  = 21;
  localparam int unsigned TargetW = 22;
  localparam int unsigned RecentW = 24;
  localparam int unsigned AccW    = CountW + 4;

  localparam logic [CountW-1:0] LenCap   = 21'd1048576;
  localparam logic [CountW-1:0] MaxReset = 21'd65536;
  localparam logic [3:0]        NameLen  = 4'd14;

  localparam logic [1:0] ActData    = 2'd0;
  localparam logic [1:0] ActClose   = 2'd1;
  localparam logic [1:0] ActRestart = 2'd2;

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;

  localparam logic [RecentW-1:0] TailCrLfCr = 24'h0D0A0D;

  localparam logic [2:0] SepCrLf = 3'd4;
  localparam logic [2:0] SepLf   = 3'd2;

  typedef enum logic [2:0] {
    CauseOpen     = 3'd0,
    CauseBody     = 3'd1,
    CauseLimit    = 3'd2,
    CauseClosed   = 3'd3,
    CauseTooLarge = 3'd4
  } cause_e;

  typedef enum logic [7:0] {
    PhFirst = 8'b0000_0001,
    PhName  = 8'b0000_0010,
    PhSkip  = 8'b0000_0100,
    PhVlead = 8'b0000_1000,
    PhPlus  = 8'b0001_0000,
    PhMinus = 8'b0010_0000,
    PhPosd  = 8'b0100_0000,
    PhNegd  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic              byte_kept;
    logic              done_res;
    logic [2:0]        end_cause;
    logic              headers_complete;
    logic [CountW-1:0] header_length;
    logic [2:0]        separator_length;
    logic [CountW-1:0] content_length;
    logic [CountW-1:0] bytes_kept;
  } out_t;

  typedef struct packed {
    logic [CountW-1:0]  kept_count;
    logic               finished;
    cause_e             stop_cause;
    logic               header_seen;
    logic [RecentW-1:0] recent_bytes;
    logic [CountW-1:0]  header_bytes;
    logic [2:0]         terminator_size;
    phase_e             line_phase;
    logic [3:0]         name_pos;
    logic [CountW-1:0]  length_value;
    logic               length_taken;
    logic [TargetW-1:0] target_bytes;
  } state_t;

  localparam state_t StateClear = '{
    kept_count:      '0,
    finished:        1'b0,
    stop_cause:      CauseOpen,
    header_seen:     1'b0,
    recent_bytes:    '0,
    header_bytes:    '0,
    terminator_size: '0,
    line_phase:      PhFirst,
    name_pos:        '0,
    length_value:    '0,
    length_taken:    1'b0,
    target_bytes:    '0
  };

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b inside {[8'h41:8'h5A]}) ? (b + 8'h20) : b;
  endfunction

  // Characters of the header name that carries the body length.
  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[design/httpf_step.sv]
// Next-state and result logic for one framer transfer.
// Depends on httpf_pkg for the payload, state and phase types.
module httpf_step (
  input  logic [httpf_pkg::CountW-1:0] max_bytes_i,
  input  httpf_pkg::state_t            state_i,
  input  httpf_pkg::in_t               item_i,
  output httpf_pkg::state_t            state_o,
  output httpf_pkg::out_t              result_o
);

  logic [7:0]                   b;
  logic [7:0]                   lc;
  logic [httpf_pkg::AccW-1:0]   acc;
  logic [httpf_pkg::CountW-1:0] pos_len;
  logic [httpf_pkg::CountW-1:0] neg_len;
  logic                         kept;
  httpf_pkg::state_t            st;

  assign b  = item_i.data_byte;
  assign lc = httpf_pkg::to_lower(b);

  assign acc = ({4'b0, state_i.length_value} << 3) + ({4'b0, state_i.length_value} << 1)
             + {{(httpf_pkg::AccW-4){1'b0}}, b[3:0]};
  assign pos_len = (acc > {4'b0, httpf_pkg::LenCap}) ? httpf_pkg::LenCap
                                                     : acc[httpf_pkg::CountW-1:0];
  assign neg_len = ((b[3:0] != 4'd0) || (state_i.length_value != '0)) ? httpf_pkg::LenCap
                                                                      : state_i.length_value;

  always_comb begin
    st   = state_i;
    kept = 1'b0;
    case (item_i.action)
      httpf_pkg::ActData: begin
        if (!state_i.finished) begin
          if (state_i.kept_count >= max_bytes_i) begin
            st.finished   = 1'b1;
            st.stop_cause = httpf_pkg::CauseLimit;
          end else begin
            kept          = 1'b1;
            st.kept_count = state_i.kept_count + 1'b1;
            if (!state_i.header_seen) begin
              if (b == httpf_pkg::ChLf) begin
                if (state_i.length_taken) begin
                  st.line_phase = httpf_pkg::PhSkip;
                end else begin
                  st.line_phase = httpf_pkg::PhName;
                  st.name_pos   = '0;
                end
              end else begin
                case (state_i.line_phase)
                  httpf_pkg::PhName: begin
                    if (b == httpf_pkg::ChColon) begin
                      if (state_i.name_pos == httpf_pkg::NameLen) begin
                        st.length_taken = 1'b1;
                        st.line_phase   = httpf_pkg::PhVlead;
                      end else begin
                        st.line_phase = httpf_pkg::PhSkip;
                      end
                    end else if (httpf_pkg::is_blank(b)) begin
                      if (state_i.name_pos != '0 && state_i.name_pos != httpf_pkg::NameLen) begin
                        st.line_phase = httpf_pkg::PhSkip;
                      end
                    end else if (state_i.name_pos < httpf_pkg::NameLen &&
                                 lc == httpf_pkg::name_char(state_i.name_pos)) begin
                      st.name_pos = state_i.name_pos + 1'b1;
                    end else begin
                      st.line_phase = httpf_pkg::PhSkip;
                    end
                  end
                  httpf_pkg::PhVlead: begin
                    if (httpf_pkg::is_blank(b)) begin
                      st.line_phase = httpf_pkg::PhVlead;
                    end else if (b == httpf_pkg::ChPlus) begin
                      st.line_phase = httpf_pkg::PhPlus;
                    end else if (b == httpf_pkg::ChMinus) begin
                      st.line_phase = httpf_pkg::PhMinus;
                    end else if (httpf_pkg::is_digit(b)) begin
                      st.length_value = pos_len;
                      st.line_phase   = httpf_pkg::PhPosd;
                    end else begin
                      st.line_phase = httpf_pkg::PhSkip;
                    end
                  end
                  httpf_pkg::PhPlus, httpf_pkg::PhPosd: begin
                    if (httpf_pkg::is_digit(b)) begin
                      st.length_value = pos_len;
                      st.line_phase   = httpf_pkg::PhPosd;
                    end else begin
                      st.line_phase = httpf_pkg::PhSkip;
                    end
                  end
                  httpf_pkg::PhMinus, httpf_pkg::PhNegd: begin
                    if (httpf_pkg::is_digit(b)) begin
                      st.length_value = neg_len;
                      st.line_phase   = httpf_pkg::PhNegd;
                    end else begin
                      st.line_phase = httpf_pkg::PhSkip;
                    end
                  end
                  default: begin
                    st.line_phase = state_i.line_phase;
                  end
                endcase
              end
              if (state_i.recent_bytes == httpf_pkg::TailCrLfCr && b == httpf_pkg::ChLf) begin
                st.header_seen     = 1'b1;
                st.header_bytes    = state_i.kept_count - 21'd3;
                st.terminator_size = httpf_pkg::SepCrLf;
              end else if (state_i.recent_bytes[7:0] == httpf_pkg::ChLf &&
                           b == httpf_pkg::ChLf) begin
                st.header_seen     = 1'b1;
                st.header_bytes    = state_i.kept_count - 21'd1;
                st.terminator_size = httpf_pkg::SepLf;
              end
              st.recent_bytes = {state_i.recent_bytes[15:0], b};
              if (st.header_seen) begin
                st.target_bytes = {1'b0, st.header_bytes}
                                + {{(httpf_pkg::TargetW-3){1'b0}}, st.terminator_size}
                                + {1'b0, st.length_value};
              end
            end
            if (st.kept_count >= max_bytes_i) begin
              st.finished   = 1'b1;
              st.stop_cause = httpf_pkg::CauseLimit;
            end else if (st.header_seen && {1'b0, st.kept_count} >= st.target_bytes) begin
              st.finished   = 1'b1;
              st.stop_cause = httpf_pkg::CauseBody;
            end else if (st.header_seen && st.target_bytes > {1'b0, max_bytes_i}) begin
              st.finished   = 1'b1;
              st.stop_cause = httpf_pkg::CauseTooLarge;
            end
          end
        end
      end
      httpf_pkg::ActClose: begin
        if (!state_i.finished) begin
          st.finished   = 1'b1;
          st.stop_cause = httpf_pkg::CauseClosed;
        end
      end
      httpf_pkg::ActRestart: begin
        st = httpf_pkg::StateClear;
      end
      default: begin
        st = state_i;
      end
    endcase
  end

  assign state_o = st;

  always_comb begin
    result_o.byte_kept        = kept;
    result_o.done_res         = st.finished;
    result_o.end_cause        = st.stop_cause;
    result_o.headers_complete = st.header_seen;
    result_o.header_length    = st.header_seen ? st.header_bytes : '0;
    result_o.separator_length = st.terminator_size;
    result_o.content_length   = st.header_seen ? st.length_value : '0;
    result_o.bytes_kept       = st.kept_count;
  end

endmodule

[design/http_request_framer_core.sv]
// HTTP request framer top level: input register, framing state, result register
// and the size-limit register behind a small APB port. Uses httpf_pkg, httpf_step.
// An accepted transfer goes from the input register to the result register.
// Throughput is one transfer per cycle unless the output stalls.
// Reset clears the framing state and both stages, and sets the limit to 65536.
// A restart transfer clears the framing state but leaves the limit register.
module http_request_framer_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  httpf_pkg::in_t        in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output httpf_pkg::out_t       out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic                         in_valid_q, in_valid_d;
  httpf_pkg::in_t               in_q;
  logic                         out_valid_q, out_valid_d;
  httpf_pkg::out_t              out_q;
  httpf_pkg::state_t            state_q, state_d;
  httpf_pkg::out_t              result;
  logic [httpf_pkg::CountW-1:0] max_q;
  logic                         in_take;
  logic                         advance;
  logic                         cfg_write;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? {11'b0, max_q} : '0;

  httpf_step u_step (
    .max_bytes_i (max_q),
    .state_i     (state_q),
    .item_i      (in_q),
    .state_o     (state_d),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= httpf_pkg::StateClear;
      max_q       <= httpf_pkg::MaxReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
      if (cfg_write) begin
        max_q <= pwdata[httpf_pkg::CountW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
